[hdl/pmi_pkg.sv]
// Shared types and constants for the four-level page map insert block.
package pmi_pkg;

   localparam int VPAGE_W   = 36;
   localparam int FRAME_W   = 40;
   localparam int ENTRY_W   = 52;
   localparam int IDX_W     = 9;
   localparam int FRAME_LSB = 12;
   localparam int LEVEL_W   = 2;

   localparam logic [1:0] ENTRY_FLAGS = 2'b11;
   localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_L3   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_L2   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_LEAF,
      ST_DONE
   } pmi_state_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic read;
      logic alloc;
      logic follow;
      logic leaf;
      logic fail;
      logic load_rsp;
   } pmi_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic present;
      logic in_pool;
      logic pool_full;
      logic last_upper;
      logic rsp_busy;
   } pmi_status_type;

endpackage

[hdl/four_level_page_map_insert.sv]
// Top level of the four-level page map insert block.
// A mapped item does a lookup and check per upper level, then a leaf write; an abort returns sooner.
// One item is walked at a time through one memory port; no new item is taken before its result.
// A held result delays the next acceptance only when the previous result has not yet been taken.
// Reset: synchronous; afterward a clearing pass zeroes the pool while no item is accepted
// (configuration writes are still taken).
module four_level_page_map_insert #(
   parameter int TABLE_PAGES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [pmi_pkg::FRAME_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pmi_pkg::VPAGE_W-1:0]   req_virt_page,
   input  logic [pmi_pkg::FRAME_W-1:0]   req_phys_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [1:0]                    rsp_new_tables,
   output logic [pmi_pkg::ENTRY_W-1:0]   rsp_leaf_entry
);

   pmi_pkg::pmi_cmd_type    cmd;
   pmi_pkg::pmi_status_type stat;

   pmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pmi_datapath #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_virt_page  (req_virt_page),
      .req_phys_frame (req_phys_frame),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_new_tables (rsp_new_tables),
      .rsp_leaf_entry (rsp_leaf_entry),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

[hdl/pmi_ctrl.sv]
// Walk controller: sequences clearing, table lookups, allocation and result hand-off.
module pmi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pmi_pkg::pmi_status_type stat,
   output pmi_pkg::pmi_cmd_type    cmd
);

   pmi_pkg::pmi_state_type state_ff;
   pmi_pkg::pmi_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmi_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmi_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = pmi_pkg::ST_IDLE;
         end
         pmi_pkg::ST_IDLE: begin
            if (req_valid) state_in = pmi_pkg::ST_LOOKUP;
         end
         pmi_pkg::ST_LOOKUP: begin
            state_in = pmi_pkg::ST_CHECK;
         end
         pmi_pkg::ST_CHECK: begin
            if (stat.present ? !stat.in_pool : stat.pool_full) begin
               state_in = pmi_pkg::ST_DONE;
            end else if (stat.last_upper) begin
               state_in = pmi_pkg::ST_LEAF;
            end else begin
               state_in = pmi_pkg::ST_LOOKUP;
            end
         end
         pmi_pkg::ST_LEAF: begin
            state_in = pmi_pkg::ST_DONE;
         end
         pmi_pkg::ST_DONE: begin
            if (!stat.rsp_busy) state_in = pmi_pkg::ST_IDLE;
         end
         default: begin
            state_in = pmi_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pmi_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         pmi_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         pmi_pkg::ST_LOOKUP: begin
            cmd.read = 1'b1;
         end
         pmi_pkg::ST_CHECK: begin
            if (stat.present) begin
               cmd.follow = stat.in_pool;
               cmd.fail   = !stat.in_pool;
            end else begin
               cmd.alloc = !stat.pool_full;
               cmd.fail  = stat.pool_full;
            end
         end
         pmi_pkg::ST_LEAF: begin
            cmd.leaf = 1'b1;
         end
         pmi_pkg::ST_DONE: begin
            cmd.load_rsp = !stat.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hdl/pmi_datapath.sv]
// Table pool memory, walk registers, page allocator and result register.
module pmi_datapath #(
   parameter int TABLE_PAGES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [pmi_pkg::FRAME_W-1:0]   csr_wr_data,
   input  logic [pmi_pkg::VPAGE_W-1:0]   req_virt_page,
   input  logic [pmi_pkg::FRAME_W-1:0]   req_phys_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [1:0]                    rsp_new_tables,
   output logic [pmi_pkg::ENTRY_W-1:0]   rsp_leaf_entry,
   input  pmi_pkg::pmi_cmd_type          cmd,
   output pmi_pkg::pmi_status_type       stat
);

   localparam int PW    = $clog2(TABLE_PAGES);
   localparam int NW    = $clog2(TABLE_PAGES + 1);
   localparam int AW    = PW + pmi_pkg::IDX_W;
   localparam int DEPTH = TABLE_PAGES * (2 ** pmi_pkg::IDX_W);
   localparam int MW    = NW + pmi_pkg::ENTRY_W;
   localparam int FW    = pmi_pkg::FRAME_W;
   localparam int EW    = pmi_pkg::ENTRY_W;

   logic [MW-1:0]  mem [DEPTH];
   logic [MW-1:0]  mem_q_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_addr;
   logic [MW-1:0]  mem_wdata;

   logic [FW-1:0]               base_ff;
   logic [pmi_pkg::VPAGE_W-1:0] vp_ff;
   logic [FW-1:0]               frame_ff;
   logic [pmi_pkg::LEVEL_W-1:0] level_ff;
   logic [PW-1:0]               page_ff;
   logic [NW-1:0]               nfp_ff;
   logic [1:0]                  made_ff;
   logic                        fail_ff;
   logic [AW-1:0]               clr_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_status_ff;
   logic [1:0]                  rsp_new_tables_ff;
   logic [EW-1:0]               rsp_leaf_entry_ff;

   logic [pmi_pkg::IDX_W-1:0] cur_idx;
   logic [NW-1:0]             tag;
   logic [NW-1:0]             page_ext;
   logic                      entry_valid;
   logic [FW-1:0]             rel;
   logic [FW-1:0]             fresh_frame;
   logic [EW-1:0]             leaf_entry;

   function automatic logic [pmi_pkg::ENTRY_W-1:0] make_entry(
      input logic [pmi_pkg::FRAME_W-1:0] frame
   );
      return {frame, {(pmi_pkg::FRAME_LSB - 2){1'b0}}, pmi_pkg::ENTRY_FLAGS};
   endfunction

   always_comb begin
      case (level_ff)
         pmi_pkg::LEVEL_ROOT: cur_idx = vp_ff[4*pmi_pkg::IDX_W-1 -: pmi_pkg::IDX_W];
         pmi_pkg::LEVEL_L3:   cur_idx = vp_ff[3*pmi_pkg::IDX_W-1 -: pmi_pkg::IDX_W];
         pmi_pkg::LEVEL_L2:   cur_idx = vp_ff[2*pmi_pkg::IDX_W-1 -: pmi_pkg::IDX_W];
         default:             cur_idx = vp_ff[pmi_pkg::IDX_W-1:0];
      endcase
   end

   assign fresh_frame = base_ff + FW'(nfp_ff);
   assign leaf_entry  = make_entry(frame_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = {page_ff, cur_idx};
      mem_wdata = '0;
      if (cmd.clear) begin
         mem_we   = 1'b1;
         mem_addr = clr_ff;
      end else if (cmd.alloc) begin
         mem_we    = 1'b1;
         mem_wdata = {NW'(nfp_ff + 1'b1), make_entry(fresh_frame)};
      end else if (cmd.leaf) begin
         mem_we    = 1'b1;
         mem_wdata = {nfp_ff, leaf_entry};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.read) mem_q_ff <= mem[mem_addr];
   end

   // An entry written before its page was handed out reads as absent once that page is allocated.
   assign tag         = mem_q_ff[MW-1 -: NW];
   assign page_ext    = NW'(page_ff);
   assign entry_valid = (tag > page_ext) || (nfp_ff <= page_ext);
   assign rel         = mem_q_ff[EW-1 -: FW] - base_ff;

   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.present    = entry_valid && mem_q_ff[0];
   assign stat.in_pool    = (rel < FW'(TABLE_PAGES));
   assign stat.pool_full  = (nfp_ff >= NW'(TABLE_PAGES));
   assign stat.last_upper = (level_ff == pmi_pkg::LEVEL_L2);
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         nfp_ff       <= NW'(1);
         clr_ff       <= '0;
         level_ff     <= pmi_pkg::LEVEL_ROOT;
         made_ff      <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) base_ff <= csr_wr_data;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.load_req) begin
            level_ff <= pmi_pkg::LEVEL_ROOT;
            made_ff  <= '0;
            fail_ff  <= 1'b0;
         end
         if (cmd.alloc || cmd.follow) level_ff <= level_ff + 1'b1;
         if (cmd.alloc) begin
            nfp_ff  <= nfp_ff + 1'b1;
            made_ff <= made_ff + 1'b1;
         end
         if (cmd.fail) fail_ff <= 1'b1;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         vp_ff    <= req_virt_page;
         frame_ff <= req_phys_frame;
         page_ff  <= '0;
      end else if (cmd.alloc) begin
         page_ff <= nfp_ff[PW-1:0];
      end else if (cmd.follow) begin
         page_ff <= rel[PW-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_status_ff     <= fail_ff;
         rsp_new_tables_ff <= made_ff;
         rsp_leaf_entry_ff <= fail_ff ? '0 : leaf_entry;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_new_tables = rsp_new_tables_ff;
   assign rsp_leaf_entry = rsp_leaf_entry_ff;

   a_nfp_range: assert property (@(posedge clock) disable iff (reset)
      (nfp_ff >= NW'(1)) && (nfp_ff <= NW'(TABLE_PAGES)))
      else $error("allocator pointer out of range");

   a_alloc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !stat.pool_full)
      else $error("allocation from an exhausted pool");

   a_alloc_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> (nfp_ff == $past(nfp_ff) + 1'b1) && (page_ff == $past(nfp_ff[PW-1:0])))
      else $error("allocation did not advance the pool");

   a_fail_zero_leaf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> (rsp_leaf_entry_ff == '0))
      else $error("aborted item carries a leaf entry");

   a_follow_in_pool: assert property (@(posedge clock) disable iff (reset)
      cmd.follow |-> stat.present && stat.in_pool)
      else $error("walk followed an entry outside the pool");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for four_level_page_map_insert: map requests checked against a table-walk predictor.
module tb;

   localparam int POOL_PAGES = 64;
   localparam int TABLE_ENTRIES = 512;
   localparam int IDLE_LIMIT = 8 * POOL_PAGES * TABLE_ENTRIES;
   localparam int DRAIN_CYCLES = 24;
   localparam logic STATUS_MAPPED = 1'b0;
   localparam logic STATUS_ABORTED = 1'b1;
   localparam logic [pmi_pkg::FRAME_W-1:0] FRAME_ALL_ONES = '1;
   localparam logic [pmi_pkg::FRAME_W-1:0] FRAME_FAR = 40'h80_0000_0000;

   typedef struct packed {
      logic                        status;
      logic [1:0]                  new_tables;
      logic [pmi_pkg::ENTRY_W-1:0] leaf_entry;
   } map_result_type;

   class page_map_scoreboard_type;
      logic [pmi_pkg::ENTRY_W-1:0] pool_entries [POOL_PAGES*TABLE_ENTRIES];
      int unsigned                 next_page;
      logic [pmi_pkg::FRAME_W-1:0] base_frame;
      map_result_type              expected_maps[$];
      int unsigned                 errors;

      function new();
         foreach (pool_entries[i]) pool_entries[i] = '0;
         next_page = 1;
         base_frame = '0;
         errors = 0;
      endfunction

      function void set_base(input logic [pmi_pkg::FRAME_W-1:0] value);
         base_frame = value;
      endfunction

      function logic [pmi_pkg::ENTRY_W-1:0] link_entry(input logic [pmi_pkg::FRAME_W-1:0] frame);
         return {frame, {(pmi_pkg::FRAME_LSB-2){1'b0}}, pmi_pkg::ENTRY_FLAGS};
      endfunction

      function int pending();
         return expected_maps.size();
      endfunction

      function void note_request(input logic [pmi_pkg::VPAGE_W-1:0] vpage,
                                 input logic [pmi_pkg::FRAME_W-1:0] frame);
         logic [pmi_pkg::IDX_W-1:0]   idx [4];
         logic [pmi_pkg::FRAME_W-1:0] rel;
         logic [pmi_pkg::ENTRY_W-1:0] ent;
         int unsigned                 page;
         int unsigned                 slot;
         int                          lvl;
         bit                          abort;
         map_result_type              res;
         for (lvl = 0; lvl < 4; lvl++) begin
            idx[lvl] = vpage[(3-lvl)*pmi_pkg::IDX_W +: pmi_pkg::IDX_W];
         end
         page = 0;
         abort = 0;
         res = '0;
         for (lvl = 0; lvl < 3 && !abort; lvl++) begin
            slot = page * TABLE_ENTRIES + idx[lvl];
            ent = pool_entries[slot];
            if (ent[0]) begin
               rel = ent[pmi_pkg::ENTRY_W-1:pmi_pkg::FRAME_LSB] - base_frame;
               if (rel >= POOL_PAGES) abort = 1;
               else page = 32'(rel);
            end else if (next_page >= POOL_PAGES) begin
               abort = 1;
            end else begin
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  pool_entries[next_page*TABLE_ENTRIES + i] = '0;
               pool_entries[slot] = link_entry(base_frame + pmi_pkg::FRAME_W'(next_page));
               page = next_page;
               next_page++;
               res.new_tables++;
            end
         end
         if (abort) begin
            res.status = STATUS_ABORTED;
            res.leaf_entry = '0;
         end else begin
            res.status = STATUS_MAPPED;
            res.leaf_entry = link_entry(frame);
            pool_entries[page*TABLE_ENTRIES + idx[3]] = res.leaf_entry;
         end
         expected_maps.push_back(res);
      endfunction

      function void check_result(input logic status, input logic [1:0] new_tables,
                                 input logic [pmi_pkg::ENTRY_W-1:0] leaf_entry);
         map_result_type want;
         if (expected_maps.size() == 0) begin
            $error("unexpected item: status %0d new_tables %0d leaf_entry %h",
                   status, new_tables, leaf_entry);
            errors++;
            return;
         end
         want = expected_maps.pop_front();
         if (want.status !== status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (want.new_tables !== new_tables) begin
            $error("new_tables mismatch: expected %0d, got %0d", want.new_tables, new_tables);
            errors++;
         end
         if (want.leaf_entry !== leaf_entry) begin
            $error("leaf_entry mismatch: expected %h, got %h", want.leaf_entry, leaf_entry);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_wr_en;
   logic [pmi_pkg::FRAME_W-1:0]  csr_wr_data;
   logic                         req_valid;
   logic                         req_stall;
   logic [pmi_pkg::VPAGE_W-1:0]  req_virt_page;
   logic [pmi_pkg::FRAME_W-1:0]  req_phys_frame;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_status;
   logic [1:0]                   rsp_new_tables;
   logic [pmi_pkg::ENTRY_W-1:0]  rsp_leaf_entry;

   page_map_scoreboard_type      sb;
   int                           idle_cycles = 0;
   bit                           quiet = 0;
   logic [pmi_pkg::IDX_W-1:0]    hot_root [3];
   logic [pmi_pkg::IDX_W-1:0]    hot_l3 [2];
   logic [pmi_pkg::IDX_W-1:0]    hot_l2 [2];

   four_level_page_map_insert #(.TABLE_PAGES(POOL_PAGES)) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_virt_page  (req_virt_page),
      .req_phys_frame (req_phys_frame),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_new_tables (rsp_new_tables),
      .rsp_leaf_entry (rsp_leaf_entry)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [pmi_pkg::IDX_W-1:0] random_idx();
      int r;
      r = $urandom_range(0, TABLE_ENTRIES - 1);
      return r[pmi_pkg::IDX_W-1:0];
   endfunction

   function automatic logic [pmi_pkg::FRAME_W-1:0] random_frame();
      int          r;
      logic [63:0] bits;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return FRAME_ALL_ONES;
      bits = {$urandom, $urandom};
      return bits[pmi_pkg::FRAME_W-1:0];
   endfunction

   function automatic logic [pmi_pkg::VPAGE_W-1:0] random_vpage();
      logic [pmi_pkg::IDX_W-1:0] leaf_idx;
      logic [63:0]               bits;
      bits = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) return bits[pmi_pkg::VPAGE_W-1:0];
      leaf_idx = random_idx();
      return {hot_root[$urandom_range(0, 2)], hot_l3[$urandom_range(0, 1)],
              hot_l2[$urandom_range(0, 1)], leaf_idx};
   endfunction

   task automatic send_item(input logic [pmi_pkg::VPAGE_W-1:0] vpage,
                            input logic [pmi_pkg::FRAME_W-1:0] frame);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_virt_page <= vpage;
      req_phys_frame <= frame;
      do @(posedge clock); while (req_stall);
      sb.note_request(vpage, frame);
   endtask

   task automatic write_base(input logic [pmi_pkg::FRAME_W-1:0] value);
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_base(value);
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_item(random_vpage(), random_frame());
   endtask

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_new_tables, rsp_leaf_entry);
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_virt_page = '0;
      req_phys_frame = '0;
      rsp_stall = 1'b0;
      hot_root[0] = '0;
      hot_root[1] = '1;
      hot_root[2] = random_idx();
      foreach (hot_l3[i]) hot_l3[i] = random_idx();
      foreach (hot_l2[i]) hot_l2[i] = random_idx();
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      write_base(FRAME_ALL_ONES);
      send_item('0, '0);
      send_item('0, FRAME_ALL_ONES);
      send_item('1, FRAME_ALL_ONES);
      send_item({9'h1ff, 9'h000, 9'h1ff, 9'h000}, 40'hAA_AAAA_AAAA);
      send_item({9'h000, 9'h1ff, 9'h000, 9'h1ff}, 40'h55_5555_5555);
      send_item({9'h000, 9'h000, 9'h1ff, 9'h155}, random_frame());
      send_item(36'hA_AAAA_AAAA, random_frame());
      send_item(36'h5_5555_5555, random_frame());
      send_item({9'h000, 9'h000, 9'h000, 9'h1ff}, random_frame());
      write_base(FRAME_FAR);
      send_item('0, random_frame());
      send_item('1, random_frame());
      write_base(FRAME_ALL_ONES);

      quiet = 1;
      send_random(60);
      quiet = 0;
      send_random(190);
      write_base('0);
      send_random(80);
      write_base(random_frame());
      send_random(60);
      write_base(FRAME_ALL_ONES);
      send_random(210);

      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
